/* rtl/lfu_pkg.sv */
// lfu_pkg: shared types and codes for the led frame update block
// item kinds, result kinds, register indexes and the led record type
// no dependencies

package lfu_pkg;

  localparam int unsigned MAX_LEDS_DEF = 64;
  localparam logic [7:0]  BRIGHTNESS_FULL = 8'd255;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned IDX_W      = 6;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic RES_DONE = 1'b0;
  localparam logic RES_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ARGB  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

  typedef struct packed {
    logic [7:0] bright;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_t;

endpackage

/* rtl/led_frame_update_with_change_detect_core.sv */
// led_frame_update_with_change_detect_core: led frame store with change detect
// entry: read in S_IDLE, compare and write in S_ENT_WR; read: S_RD_DATA then
// S_RESULT to the output register; end: S_TAIL_WR/S_TAIL_RD clear each tail led,
// S_RESULT at once if none; one item at a time, in_stall is high outside S_IDLE;
// after reset a clearing sweep over every entry holds in_stall high while
// configuration writes are still taken; depends on lfu_pkg, lfu_store

module led_frame_update_with_change_detect_core
  import lfu_pkg::*;
#(
  parameter int unsigned MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            kind,
  input  logic [7:0]            brightness,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [IDX_W-1:0]      read_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  result_kind,
  output logic                  refresh_request,
  output logic [7:0]            out_brightness,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned PW = $clog2(MAX_LEDS + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ENT_WR  = 6'b000010,
    S_TAIL_RD = 6'b000100,
    S_TAIL_WR = 6'b001000,
    S_RD_DATA = 6'b010000,
    S_RESULT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic               argb_mode;
  logic [COUNT_W-1:0] led_count;
  logic [PW-1:0]      wp;
  logic [PW-1:0]      eff_count;
  logic               change_seen;
  led_t               item_led;
  logic               res_kind;
  logic               res_refresh;
  led_t               res_led;

  logic          in_accept;
  logic          out_free;
  logic          store_ready;
  logic          store_we;
  logic [AW-1:0] store_waddr;
  led_t          store_wdata;
  logic [AW-1:0] store_raddr;
  led_t          store_rdata;
  logic          entry_diff;
  logic          tail_diff;
  logic          read_in_range;
  logic [PW-1:0] wp_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || !store_ready;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign wp_inc    = wp + 1'b1;

  always_comb begin
    if (32'(led_count) > 32'(MAX_LEDS)) begin
      eff_count = PW'(MAX_LEDS);
    end else begin
      eff_count = PW'(led_count);
    end
  end

  assign read_in_range = 32'(read_index) < 32'(MAX_LEDS);

  assign entry_diff = (store_rdata.red != item_led.red)
                   || (store_rdata.green != item_led.green)
                   || (store_rdata.blue != item_led.blue)
                   || (argb_mode && (store_rdata.bright != item_led.bright));
  assign tail_diff  = (store_rdata.red != 8'd0) || (store_rdata.green != 8'd0)
                   || (store_rdata.blue != 8'd0);

  always_comb begin
    store_raddr = AW'(wp);
    if (state == S_IDLE && kind == KIND_READ) begin
      store_raddr = AW'(read_index);
    end
    store_we    = (state == S_ENT_WR) || (state == S_TAIL_WR);
    store_waddr = AW'(wp);
    store_wdata = '0;
    if (state == S_ENT_WR) begin
      store_wdata        = item_led;
      store_wdata.bright = argb_mode ? item_led.bright : BRIGHTNESS_FULL;
    end
  end

  lfu_store #(
    .MAX_LEDS (MAX_LEDS),
    .AW       (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata),
    .ready (store_ready)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (kind)
            KIND_ENTRY: state_next = (wp < eff_count) ? S_ENT_WR : S_IDLE;
            KIND_END:   state_next = (wp < eff_count) ? S_TAIL_WR : S_RESULT;
            KIND_READ:  state_next = read_in_range ? S_RD_DATA : S_RESULT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ENT_WR:  state_next = S_IDLE;
      S_TAIL_RD: state_next = S_TAIL_WR;
      S_TAIL_WR: state_next = (wp_inc < eff_count) ? S_TAIL_RD : S_RESULT;
      S_RD_DATA: state_next = S_RESULT;
      S_RESULT:  state_next = out_free ? S_IDLE : S_RESULT;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      argb_mode   <= 1'b0;
      led_count   <= COUNT_W'(64);
      wp          <= '0;
      change_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ARGB:  argb_mode <= cfg_data[0];
          CFG_COUNT: led_count <= cfg_data[COUNT_W-1:0];
          default:   ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_accept && kind == KIND_END && !(wp < eff_count)) begin
            wp          <= '0;
            change_seen <= 1'b0;
          end
        end
        S_ENT_WR: begin
          wp <= wp_inc;
          if (entry_diff) begin
            change_seen <= 1'b1;
          end
        end
        S_TAIL_WR: begin
          if (wp_inc < eff_count) begin
            wp <= wp_inc;
            if (tail_diff) begin
              change_seen <= 1'b1;
            end
          end else begin
            wp          <= '0;
            change_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // pending result, waits in S_RESULT for the output register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          item_led.bright <= brightness;
          item_led.red    <= red;
          item_led.green  <= green;
          item_led.blue   <= blue;
          res_led         <= '0;
          res_kind        <= (kind == KIND_READ) ? RES_READ : RES_DONE;
          res_refresh     <= (kind == KIND_END) ? change_seen : 1'b0;
        end
      end
      S_TAIL_WR: res_refresh <= change_seen || tail_diff;
      S_RD_DATA: res_led <= store_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      result_kind     <= res_kind;
      refresh_request <= res_refresh;
      out_brightness  <= res_led.bright;
      out_red         <= res_led.red;
      out_green       <= res_led.green;
      out_blue        <= res_led.blue;
    end
  end

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    32'(wp) <= 32'(MAX_LEDS))
    else $error("write position beyond store depth");

  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESULT))
    else $error("output loaded outside result state");

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    !store_ready |-> in_stall)
    else $error("input taken during clearing sweep");

  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept && kind == KIND_END |=> in_stall)
    else $error("end transaction did not hold the input");

endmodule

/* rtl/lfu_store.sv */
// lfu_store: led color memory, one write and one registered read port
// runs a clearing sweep over every entry after reset
// depends on lfu_pkg

module lfu_store
  import lfu_pkg::*;
#(
  parameter int unsigned MAX_LEDS = MAX_LEDS_DEF,
  parameter int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  led_t          wdata,
  input  logic [AW-1:0] raddr,
  output led_t          rdata,
  output logic          ready
);

  led_t          mem [MAX_LEDS];
  logic          clr_active;
  logic [AW-1:0] clr_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  led_t          mem_wdata;

  always_comb begin
    mem_we    = we;
    mem_waddr = waddr;
    mem_wdata = wdata;
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(MAX_LEDS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  assign ready = !clr_active;

endmodule

/* test/testbench.sv */
// testbench for led_frame_update_with_change_detect_core: directed and random led
// sequences checked against a shadow copy of the led store and change flag
// depends on lfu_pkg and the core rtl
`timescale 1ns / 100ps

module testbench;
  import lfu_pkg::*;

  localparam int unsigned LEDS          = MAX_LEDS_DEF;
  localparam int unsigned SETTLE_CYCLES = 2 * LEDS + 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;

  typedef struct packed {
    logic kind;
    logic refresh;
    led_t led;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            kind = KIND_ENTRY;
  logic [7:0]            brightness = '0;
  logic [7:0]            red = '0;
  logic [7:0]            green = '0;
  logic [7:0]            blue = '0;
  logic [IDX_W-1:0]      read_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  result_kind;
  logic                  refresh_request;
  logic [7:0]            out_brightness;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ARGB;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  led_t             shadow_leds [LEDS];
  int unsigned      shadow_pos = 0;
  logic             shadow_changed = 1'b0;
  logic             shadow_argb = 1'b0;
  logic [COUNT_W-1:0] shadow_count = 7'd64;
  frame_result_t    results_due [$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned next_gap = 0;
  int unsigned stall_left = 0;
  bit          input_parked = 1'b1;
  bit          calm = 1'b0;
  logic        hold_req = 1'b0;

  led_frame_update_with_change_detect_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .brightness      (brightness),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .read_index      (read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .refresh_request (refresh_request),
    .out_brightness  (out_brightness),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < LEDS; i++) shadow_leds[i] = '0;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic update_shadow(input logic [1:0] k, input led_t v, input logic [IDX_W-1:0] idx);
    int unsigned lim;
    frame_result_t res;
    lim = (shadow_count > LEDS) ? LEDS : shadow_count;
    res = '0;
    case (k)
      KIND_ENTRY: begin
        if (shadow_pos < lim) begin
          if (shadow_leds[shadow_pos].red != v.red || shadow_leds[shadow_pos].green != v.green ||
              shadow_leds[shadow_pos].blue != v.blue)
            shadow_changed = 1'b1;
          if (shadow_argb) begin
            if (shadow_leds[shadow_pos].bright != v.bright) shadow_changed = 1'b1;
            shadow_leds[shadow_pos].bright = v.bright;
          end else begin
            shadow_leds[shadow_pos].bright = BRIGHTNESS_FULL;
          end
          shadow_leds[shadow_pos].red   = v.red;
          shadow_leds[shadow_pos].green = v.green;
          shadow_leds[shadow_pos].blue  = v.blue;
          shadow_pos++;
        end
      end
      KIND_END: begin
        for (int unsigned i = shadow_pos; i < lim; i++) begin
          if (shadow_leds[i].red != 0 || shadow_leds[i].green != 0 || shadow_leds[i].blue != 0)
            shadow_changed = 1'b1;
          shadow_leds[i] = '0;
        end
        res.kind    = RES_DONE;
        res.refresh = shadow_changed;
        results_due.push_back(res);
        shadow_pos     = 0;
        shadow_changed = 1'b0;
      end
      KIND_READ: begin
        res.kind = RES_READ;
        if (idx < LEDS) res.led = shadow_leds[idx];
        results_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report("result with none due");
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", 8'(result_kind), 8'(want.kind));
        check_field("refresh_request", 8'(refresh_request), 8'(want.refresh));
        check_field("out_brightness", out_brightness, want.led.bright);
        check_field("out_red", out_red, want.led.red);
        check_field("out_green", out_green, want.led.green);
        check_field("out_blue", out_blue, want.led.blue);
      end
    end
  end

  // result receiver: random stall after each transaction, long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      stall_left = HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (!rst && out_valid && !out_stall) begin
      stall_left = calm ? 0 : $urandom_range(0, 10);
      if (stall_left != 0) out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end
  end

  task automatic park_input;
    if (!input_parked) begin
      in_valid     <= 1'b0;
      input_parked = 1'b1;
    end
  endtask

  task automatic send_item(input logic [1:0] k, input led_t v, input logic [IDX_W-1:0] idx);
    repeat (next_gap) @(posedge clk);
    in_valid     <= 1'b1;
    kind         <= k;
    brightness   <= v.bright;
    red          <= v.red;
    green        <= v.green;
    blue         <= v.blue;
    read_index   <= idx;
    input_parked = 1'b0;
    do @(posedge clk); while (in_stall);
    update_shadow(k, v, idx);
    if (k != KIND_UNUSED) items_sent++;
    next_gap = calm ? 0 : $urandom_range(0, 10);
    if (next_gap != 0) begin
      in_valid     <= 1'b0;
      input_parked = 1'b1;
    end
  endtask

  task automatic send_entry(input logic [31:0] val);
    send_item(KIND_ENTRY, led_t'(val), IDX_W'($urandom_range(0, LEDS - 1)));
  endtask

  task automatic send_end;
    send_item(KIND_END, led_t'($urandom), IDX_W'($urandom_range(0, LEDS - 1)));
  endtask

  task automatic send_read(input int unsigned idx);
    send_item(KIND_READ, led_t'($urandom), IDX_W'(idx));
  endtask

  task automatic send_noise;
    send_item(KIND_UNUSED, led_t'($urandom), IDX_W'($urandom_range(0, LEDS - 1)));
  endtask

  // wait until all results are in and any trailing entry or sweep has finished
  task automatic settle;
    park_input;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic argb_v, input logic [COUNT_W-1:0] count_v);
    park_input;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ARGB;
    cfg_data  <= {{(CFG_DATA_W - 1){1'b0}}, argb_v};
    do @(posedge clk); while (!cfg_ready);
    shadow_argb = argb_v;
    cfg_index <= CFG_COUNT;
    cfg_data  <= CFG_DATA_W'(count_v);
    do @(posedge clk); while (!cfg_ready);
    shadow_count = count_v;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state;
    set_config(1'b0, 7'd2);
    send_read(0);
    send_read(LEDS - 1);
  endtask

  task automatic test_rgb_frames;
    send_entry(32'h00_00_00_00);
    send_entry(32'hff_ff_ff_ff);
    send_entry(32'h5a_a5_5a_a5);
    send_end;
    send_read(0);
    send_read(1);
    send_read(LEDS - 1);
    send_entry(32'h00_ff_ff_ff);
    send_end;
    send_end;
    send_end;
    send_noise;
  endtask

  task automatic test_argb_frames;
    settle;
    set_config(1'b1, 7'd2);
    send_entry(32'h12_00_00_00);
    send_end;
    send_entry(32'h12_00_00_00);
    send_end;
    send_read(0);
    // mode switch in the middle of a sequence
    send_entry(32'h34_01_02_03);
    settle;
    set_config(1'b0, 7'd2);
    send_entry(32'h56_04_05_06);
    send_end;
    send_read(0);
    send_read(1);
  endtask

  task automatic test_count_extremes;
    settle;
    set_config(1'b0, 7'd0);
    send_entry(32'hff_ff_ff_ff);
    send_end;
    settle;
    set_config(1'b1, 7'd127);
    send_end;
    settle;
    set_config(1'b0, 7'd8);
    repeat (5) send_entry($urandom);
    // count lowered below the write position
    settle;
    set_config(1'b0, 7'd3);
    send_end;
    send_read(4);
  endtask

  task automatic test_backpressure;
    settle;
    calm = 1'b1;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (24) send_read($urandom_range(0, LEDS - 1));
    settle;
    calm = 1'b0;
  endtask

  task automatic run_random_sequence(input int unsigned lim);
    int unsigned style, len, altered;
    bit reuse;
    led_t v;
    style = $urandom_range(0, 9);
    if (style <= 5) len = lim;
    else if (style == 8) len = lim + $urandom_range(1, 3);
    else len = $urandom_range(0, lim);
    reuse   = ($urandom_range(0, 2) == 0);
    altered = $urandom_range(0, 1) ? $urandom_range(0, len) : len;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_read(($urandom_range(0, 1) && lim != 0) ? $urandom_range(0, lim - 1)
                                                     : $urandom_range(0, LEDS - 1));
      if ($urandom_range(0, 31) == 0) send_noise;
      if (reuse && shadow_pos < LEDS && i != altered) begin
        v = shadow_leds[shadow_pos];
        if (!shadow_argb) v.bright = 8'($urandom);
      end else begin
        v = led_t'($urandom);
      end
      send_item(KIND_ENTRY, v, IDX_W'($urandom_range(0, LEDS - 1)));
    end
    // style 9 leaves the sequence open
    if (style != 9) send_end;
  endtask

  task automatic test_random_frames(input int unsigned quota);
    int unsigned target, sel, lim;
    logic [COUNT_W-1:0] cnt;
    target = items_sent + quota;
    while (items_sent < target) begin
      settle;
      calm = ($urandom_range(0, 3) == 0);
      sel  = $urandom_range(0, 19);
      if (sel == 0) cnt = 7'd0;
      else if (sel == 1) cnt = 7'd64;
      else if (sel == 2) cnt = COUNT_W'($urandom_range(65, 127));
      else cnt = COUNT_W'($urandom_range(1, 10));
      set_config(1'($urandom_range(0, 1)), cnt);
      lim = (cnt > LEDS) ? LEDS : cnt;
      repeat ($urandom_range(2, 6)) run_random_sequence(lim);
    end
    calm = 1'b0;
  endtask

  initial begin
    int unsigned guard;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_state;
    test_rgb_frames;
    test_argb_frames;
    test_count_extremes;
    test_backpressure;
    test_random_frames(800);
    park_input;
    for (guard = 0; guard < DRAIN_LIMIT && results_due.size() != 0; guard++)
      @(posedge clk);
    if (results_due.size() != 0) report($sformatf("%0d results never arrived", results_due.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/lfu_pkg.sv
rtl/lfu_store.sv
rtl/led_frame_update_with_change_detect_core.sv
test/testbench.sv
